@@ rtl/vector_unpack_mask_engine_unit_defines.svh @@
// assertion macros used by the vector unpack mask engine checker
`ifndef VECTOR_UNPACK_MASK_ENGINE_UNIT_DEFINES_SVH
`define VECTOR_UNPACK_MASK_ENGINE_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define VUMASK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vumask assertion failed");

// antecedent implies consequent in the next cycle
`define VUMASK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vumask assertion failed");

`endif

@@ rtl/vumask_pkg.sv @@
// types, constants and codes of the vector unpack mask engine
`default_nettype none
package vumask_pkg;

	// mask table geometry
	localparam int CYCLE_ROWS = 4;
	localparam int ROW_AW     = (CYCLE_ROWS > 1) ? $clog2(CYCLE_ROWS) : 1;
	localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(CYCLE_ROWS - 1);
	localparam int LANES      = 4;
	localparam int KINDS      = 3;
	localparam int LANE_W     = 32;

	typedef logic [LANE_W-1:0] lane_t;

	// command codes
	localparam logic CMD_UNPACK = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	// element size codes (low two format bits)
	localparam logic [1:0] SIZE_32  = 2'd0;
	localparam logic [1:0] SIZE_16  = 2'd1;
	localparam logic [1:0] SIZE_8   = 2'd2;
	localparam logic [1:0] SIZE_BAD = 2'd3;

	// vector count codes (high two format bits)
	localparam logic [1:0] COUNT_S  = 2'd0;
	localparam logic [1:0] COUNT_V2 = 2'd1;
	localparam logic [1:0] COUNT_V3 = 2'd2;
	localparam logic [1:0] COUNT_V4 = 2'd3;

	// colour format
	localparam logic [3:0] FMT_V4_5 = 4'd15;

	// mask kinds (high two address bits)
	localparam logic [1:0] KIND_KEEP     = 2'd0;
	localparam logic [1:0] KIND_OLD_KEEP = 2'd1;
	localparam logic [1:0] KIND_FILL     = 2'd2;

	// mask words of one row, all lanes
	typedef struct packed {
		lane_t [LANES-1:0] keep;
		lane_t [LANES-1:0] old_keep;
		lane_t [LANES-1:0] fill;
	} mask_set_t;

	// table access control from the top level
	typedef struct packed {
		logic       wr_en;
		logic [5:0] wr_addr;
		lane_t      wr_data;
		logic       rd_en;
		logic [1:0] rd_row;
	} table_ctl_t;

endpackage
`default_nettype wire

@@ rtl/vumask_ifs.sv @@
// word channels of the vector unpack mask engine
`default_nettype none
interface vumask_req_if import vumask_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        command;
	logic [63:0] source_low;
	logic [63:0] source_high;
	logic [63:0] old_dest_low;
	logic [63:0] old_dest_high;
	logic [3:0]  format;
	logic        is_unsigned;
	logic        apply_mask;
	logic [1:0]  cycle_row;
	logic [5:0]  mask_address;
	lane_t       mask_word;

	modport source (
		output valid, command, source_low, source_high, old_dest_low, old_dest_high,
		output format, is_unsigned, apply_mask, cycle_row, mask_address, mask_word,
		input  ready
	);
	modport sink (
		input  valid, command, source_low, source_high, old_dest_low, old_dest_high,
		input  format, is_unsigned, apply_mask, cycle_row, mask_address, mask_word,
		output ready
	);
endinterface

interface vumask_rsp_if import vumask_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [63:0] dest_low;
	logic [63:0] dest_high;
	logic        bad_format;

	modport source (output valid, dest_low, dest_high, bad_format, input ready);
	modport sink (input valid, dest_low, dest_high, bad_format, output ready);
endinterface
`default_nettype wire

@@ rtl/vumask_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module vumask_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/vumask_table.sv @@
// mask table: one ram per kind and lane, indexed by row, with valid bits
`default_nettype none
module vumask_table import vumask_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire table_ctl_t ctl,
	output mask_set_t       masks
);

	logic [1:0]        wr_kind;
	logic [1:0]        wr_row;
	logic [1:0]        wr_lane;
	logic              wr_ok;
	logic [ROW_AW-1:0] wr_idx;
	logic [ROW_AW-1:0] rd_idx;

	lane_t                    rdata [KINDS][LANES];
	logic [CYCLE_ROWS-1:0]    vld_q [KINDS][LANES];
	logic [KINDS*LANES-1:0]   vld_s1;

	// address split and range check
	assign wr_kind = ctl.wr_addr[5:4];
	assign wr_row  = ctl.wr_addr[3:2];
	assign wr_lane = ctl.wr_addr[1:0];
	assign wr_ok   = ctl.wr_en && (32'(wr_kind) < KINDS) && (32'(wr_row) < CYCLE_ROWS);
	assign wr_idx  = ROW_AW'(wr_row);

	// clamp the read row to the last implemented row
	assign rd_idx = (32'(ctl.rd_row) > CYCLE_ROWS - 1) ? ROW_LAST : ROW_AW'(ctl.rd_row);

	for (genvar k = 0; k < KINDS; k++) begin : g_kind
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic we;
			assign we = wr_ok && (wr_kind == 2'(k)) && (wr_lane == 2'(l));

			vumask_ram #(
				.WIDTH (LANE_W),
				.DEPTH (CYCLE_ROWS)
			) u_ram (
				.clk   (clk),
				.we    (we),
				.waddr (wr_idx),
				.wdata (ctl.wr_data),
				.re    (ctl.rd_en),
				.raddr (rd_idx),
				.rdata (rdata[k][l])
			);

			// written flags, cleared by reset
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[k][l] <= '0;
				end else if (we) begin
					vld_q[k][l][wr_idx] <= 1'b1;
				end
			end

			// flag sampled with the ram read
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s1[k*LANES+l] <= 1'b0;
				end else if (ctl.rd_en) begin
					vld_s1[k*LANES+l] <= vld_q[k][l][rd_idx];
				end
			end
		end
	end

	// unwritten words read as zero
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			masks.keep[l]     = vld_s1[0*LANES+l] ? rdata[0][l] : '0;
			masks.old_keep[l] = vld_s1[1*LANES+l] ? rdata[1][l] : '0;
			masks.fill[l]     = vld_s1[2*LANES+l] ? rdata[2][l] : '0;
		end
	end

endmodule
`default_nettype wire

@@ rtl/vumask_unpack.sv @@
// lane unpack, duplication and mask merge for one word
`default_nettype none
module vumask_unpack import vumask_pkg::*; (
	input  wire logic [127:0] source,
	input  wire logic [127:0] old_dest,
	input  wire logic [3:0]   format,
	input  wire logic         is_unsigned,
	input  wire logic         apply_mask,
	input  wire mask_set_t    masks,
	output logic [127:0]      dest,
	output logic              bad_format
);

	logic [1:0]   size;
	logic [1:0]   count;
	lane_t        elem [LANES];
	lane_t        data [LANES];
	lane_t        old  [LANES];
	logic [15:0]  half;
	logic [7:0]   byt;

	assign size       = format[1:0];
	assign count      = format[3:2];
	assign bad_format = (size == SIZE_BAD) && (format != FMT_V4_5);

	// extract and extend the element of each lane position
	always_comb begin
		half = '0;
		byt  = '0;
		for (int l = 0; l < LANES; l++) begin
			half = source[16*l +: 16];
			byt  = source[8*l +: 8];
			case (size)
				SIZE_16: elem[l] = is_unsigned ? {16'b0, half} : {{16{half[15]}}, half};
				SIZE_8:  elem[l] = is_unsigned ? {24'b0, byt} : {{24{byt[7]}}, byt};
				default: elem[l] = source[32*l +: 32];
			endcase
		end
	end

	// lane duplication and zero fill
	always_comb begin
		if (format == FMT_V4_5) begin
			data[0] = {24'b0, source[4:0], 3'b0};
			data[1] = {24'b0, source[9:5], 3'b0};
			data[2] = {24'b0, source[14:10], 3'b0};
			data[3] = {24'b0, source[15], 7'b0};
		end else begin
			case (count)
				COUNT_S: begin
					data[0] = elem[0];
					data[1] = elem[0];
					data[2] = elem[0];
					data[3] = elem[0];
				end
				COUNT_V2: begin
					data[0] = elem[0];
					data[1] = elem[1];
					data[2] = elem[0];
					data[3] = (size == SIZE_32) ? '0 : elem[1];
				end
				COUNT_V3: begin
					data[0] = elem[0];
					data[1] = elem[1];
					data[2] = elem[2];
					data[3] = '0;
				end
				default: begin
					data[0] = elem[0];
					data[1] = elem[1];
					data[2] = elem[2];
					data[3] = elem[3];
				end
			endcase
		end
	end

	// merge with previous lanes
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			old[l] = old_dest[32*l +: 32];
			if (bad_format) begin
				dest[32*l +: 32] = old[l];
			end else if (apply_mask) begin
				dest[32*l +: 32] = (data[l] & masks.keep[l]) | (old[l] & masks.old_keep[l])
					| masks.fill[l];
			end else begin
				dest[32*l +: 32] = data[l];
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/vector_unpack_mask_engine_unit.sv @@
// top level of the vector unpack mask engine
// Takes one word per cycle on req while req.ready is high, which it is unless
// the input stage is full and a stalled rsp holds the output register, and
// returns one result word on rsp for each unpack command; a load command
// writes one mask table word, when its address is in range, in the cycle it is
// accepted and returns nothing. The input stage registers the word while the
// per-lane mask rams are read, followed by the unpack and merge logic into the
// output register. The table reads as zero right after reset through per-word
// written flags, so there is no clearing pass. A load is visible to any unpack accepted later.
`default_nettype none
module vector_unpack_mask_engine_unit import vumask_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	vumask_req_if.sink   req,
	vumask_rsp_if.source rsp
);

	logic         accept;
	logic         take_unpack;
	logic         out_load;
	table_ctl_t   tbl_ctl;
	mask_set_t    masks;

	logic         valid_s1;
	logic [127:0] source_s1;
	logic [127:0] old_dest_s1;
	logic [3:0]   format_s1;
	logic         is_unsigned_s1;
	logic         apply_mask_s1;

	logic [127:0] dest;
	logic         bad;

	logic         out_valid_q;
	logic [127:0] dest_q;
	logic         bad_format_q;

	// handshake
	assign out_load    = !out_valid_q || rsp.ready;
	assign req.ready   = !valid_s1 || out_load;
	assign accept      = req.valid && req.ready;
	assign take_unpack = accept && (req.command == CMD_UNPACK);

	// table access
	assign tbl_ctl.wr_en   = accept && (req.command == CMD_LOAD);
	assign tbl_ctl.wr_addr = req.mask_address;
	assign tbl_ctl.wr_data = req.mask_word;
	assign tbl_ctl.rd_en   = take_unpack;
	assign tbl_ctl.rd_row  = req.cycle_row;

	vumask_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tbl_ctl),
		.masks  (masks)
	);

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= take_unpack;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (take_unpack) begin
			source_s1      <= {req.source_high, req.source_low};
			old_dest_s1    <= {req.old_dest_high, req.old_dest_low};
			format_s1      <= req.format;
			is_unsigned_s1 <= req.is_unsigned;
			apply_mask_s1  <= req.apply_mask;
		end
	end

	vumask_unpack u_unpack (
		.source      (source_s1),
		.old_dest    (old_dest_s1),
		.format      (format_s1),
		.is_unsigned (is_unsigned_s1),
		.apply_mask  (apply_mask_s1),
		.masks       (masks),
		.dest        (dest),
		.bad_format  (bad)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			dest_q       <= dest;
			bad_format_q <= bad;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.dest_low   = dest_q[63:0];
	assign rsp.dest_high  = dest_q[127:64];
	assign rsp.bad_format = bad_format_q;

endmodule
`default_nettype wire

@@ rtl/vumask_checker.sv @@
// port checker for the vector unpack mask engine, bound to the top level
`default_nettype none
`include "vector_unpack_mask_engine_unit_defines.svh"
module vumask_checker import vumask_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        req_command,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [63:0] rsp_dest_low,
	input wire logic        rsp_bad_format
);

	logic unpack_taken;
	logic rsp_stall;

	// handshake terms
	assign unpack_taken = req_valid && req_ready && (req_command == CMD_UNPACK);
	assign rsp_stall    = rsp_valid && !rsp_ready;

	// a new result traces back through the input stage to an accepted unpack word
	`VUMASK_ASSERT_IMP(a_rsp_from_unpack, clk, arst_n, $rose(rsp_valid), $past(unpack_taken, 2))

	// with the output empty the block takes input
	`VUMASK_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !rsp_valid, req_ready)

	// a stalled result stays
	`VUMASK_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid)

	// a stalled result keeps its low dest half and its bad format flag
	`VUMASK_ASSERT_NXT(a_rsp_stable, clk, arst_n, rsp_stall, $stable({rsp_dest_low, rsp_bad_format}))

endmodule

bind vector_unpack_mask_engine_unit vumask_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_command    (req.command),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_dest_low   (rsp.dest_low),
	.rsp_bad_format (rsp.bad_format)
);
`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench of the vector unpack mask engine top level
`timescale 1ns / 100ps
module testbench;
	import vumask_pkg::*;

	localparam int MASK_DEPTH       = KINDS * CYCLE_ROWS * LANES;
	localparam int RANDOM_PER_PHASE = 175;
	localparam int CYCLE_LIMIT      = 200000;

	// one request word
	typedef struct {
		logic        command;
		logic [63:0] source_low;
		logic [63:0] source_high;
		logic [63:0] old_dest_low;
		logic [63:0] old_dest_high;
		logic [3:0]  format;
		logic        is_unsigned;
		logic        apply_mask;
		logic [1:0]  cycle_row;
		logic [5:0]  mask_address;
		lane_t       mask_word;
	} req_word_t;

	// one response word
	typedef struct {
		logic [63:0] dest_low;
		logic [63:0] dest_high;
		logic        bad_format;
	} unpack_result_t;

	// directed stimulus entry, result typed in or left to the predictor
	typedef struct {
		req_word_t      w;
		bit             typed;
		unpack_result_t result;
	} directed_entry_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	vumask_req_if req_ch ();
	vumask_rsp_if rsp_ch ();

	vector_unpack_mask_engine_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	lane_t           mask_copy [MASK_DEPTH];
	unpack_result_t  pending_results [$];
	directed_entry_t directed_rows [$];
	unpack_result_t  no_result;

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int cycle_count  = 0;
	int n_errors     = 0;
	int n_unpacks    = 0;
	int n_masked     = 0;
	int n_bad        = 0;
	int n_loads      = 0;
	int n_results    = 0;

	// clock
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// one element of the packed source, sign- or zero-extended
	function automatic lane_t element_at(input logic [127:0] src, input logic [1:0] size,
			input int idx, input logic zx);
		logic [15:0] h;
		logic [7:0]  b;
		h = src[idx*16 +: 16];
		b = src[idx*8 +: 8];
		case (size)
		SIZE_32: return src[idx*32 +: 32];
		SIZE_16: return zx ? {16'h0, h} : {{16{h[15]}}, h};
		default: return zx ? {24'h0, b} : {{24{b[7]}}, b};
		endcase
	endfunction

	// expected lanes of one unpack word against the current mask table
	function automatic unpack_result_t unpack_lanes(input req_word_t w);
		logic [127:0]   src;
		logic [1:0]     size;
		logic [1:0]     count;
		logic [1:0]     row;
		logic           bad;
		lane_t          old [LANES];
		lane_t          data [LANES];
		lane_t          lanes [LANES];
		int             base;
		unpack_result_t r;
		src   = {w.source_high, w.source_low};
		size  = w.format[1:0];
		count = w.format[3:2];
		old   = '{w.old_dest_low[31:0], w.old_dest_low[63:32],
			w.old_dest_high[31:0], w.old_dest_high[63:32]};
		bad   = (size == SIZE_BAD) && (w.format != FMT_V4_5);
		for (int k = 0; k < LANES; k++)
			data[k] = '0;
		// colour format takes the low 16 source bits
		if (w.format == FMT_V4_5) begin
			data[0] = {24'h0, src[4:0], 3'b0};
			data[1] = {24'h0, src[9:5], 3'b0};
			data[2] = {24'h0, src[14:10], 3'b0};
			data[3] = {24'h0, src[15], 7'b0};
		end else if (!bad) begin
			for (int k = 0; k < LANES; k++)
				data[k] = (k <= count) ? element_at(src, size, k, w.is_unsigned) : '0;
			// lane duplication and zero fill
			case (count)
			COUNT_S: begin
				data[1] = data[0];
				data[2] = data[0];
				data[3] = data[0];
			end
			COUNT_V2: begin
				data[2] = data[0];
				data[3] = (size == SIZE_32) ? '0 : data[1];
			end
			default: ;
			endcase
		end
		row = w.cycle_row;
		if (row > ROW_LAST)
			row = ROW_LAST;
		// merge through the mask set of the row
		for (int k = 0; k < LANES; k++) begin
			base = row * LANES + k;
			if (bad)
				lanes[k] = old[k];
			else if (w.apply_mask)
				lanes[k] = (data[k] & mask_copy[KIND_KEEP * CYCLE_ROWS * LANES + base])
					| (old[k] & mask_copy[KIND_OLD_KEEP * CYCLE_ROWS * LANES + base])
					| mask_copy[KIND_FILL * CYCLE_ROWS * LANES + base];
			else
				lanes[k] = data[k];
		end
		r.dest_low   = {lanes[1], lanes[0]};
		r.dest_high  = {lanes[3], lanes[2]};
		r.bad_format = bad;
		return r;
	endfunction

	function automatic req_word_t unpack_word(input logic [3:0] fmt, input logic zx,
			input logic mask, input logic [1:0] row, input logic [63:0] slo, shi, olo, ohi);
		req_word_t w;
		w = '{default: '0};
		w.command       = CMD_UNPACK;
		w.format        = fmt;
		w.is_unsigned   = zx;
		w.apply_mask    = mask;
		w.cycle_row     = row;
		w.source_low    = slo;
		w.source_high   = shi;
		w.old_dest_low  = olo;
		w.old_dest_high = ohi;
		return w;
	endfunction

	function automatic req_word_t load_word(input logic [5:0] addr, input lane_t data);
		req_word_t w;
		w = '{default: '0};
		w.command      = CMD_LOAD;
		w.mask_address = addr;
		w.mask_word    = data;
		return w;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random word: mostly unpacks with random content, some table loads
	function automatic req_word_t random_word();
		req_word_t w;
		w.command       = ($urandom_range(99) < 25) ? CMD_LOAD : CMD_UNPACK;
		w.source_low    = rand64();
		w.source_high   = rand64();
		w.old_dest_low  = rand64();
		w.old_dest_high = rand64();
		w.format        = 4'($urandom_range(15));
		w.is_unsigned   = 1'($urandom_range(1));
		w.apply_mask    = ($urandom_range(99) < 70);
		w.cycle_row     = 2'($urandom_range(3));
		w.mask_address  = ($urandom_range(7) == 0) ? 6'($urandom_range(63, MASK_DEPTH))
			: 6'($urandom_range(MASK_DEPTH - 1));
		case ($urandom_range(7))
		0, 1:    w.mask_word = '1;
		2:       w.mask_word = '0;
		3:       w.mask_word = 32'h0000_ffff << (16 * $urandom_range(1));
		default: w.mask_word = $urandom;
		endcase
		return w;
	endfunction

	task automatic add_checked(input req_word_t w);
		directed_entry_t entry;
		entry.w      = w;
		entry.typed  = 1'b0;
		entry.result = no_result;
		directed_rows.push_back(entry);
	endtask

	task automatic add_typed(input req_word_t w, input logic [63:0] lo, hi, input logic bad);
		directed_entry_t entry;
		entry.w      = w;
		entry.typed  = 1'b1;
		entry.result = '{dest_low: lo, dest_high: hi, bad_format: bad};
		directed_rows.push_back(entry);
	endtask

	// drive one word from a falling edge, predict on acceptance, return at a falling edge
	task automatic send_word(input req_word_t w, input bit typed, input unpack_result_t typed_result);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.command       <= w.command;
		req_ch.source_low    <= w.source_low;
		req_ch.source_high   <= w.source_high;
		req_ch.old_dest_low  <= w.old_dest_low;
		req_ch.old_dest_high <= w.old_dest_high;
		req_ch.format        <= w.format;
		req_ch.is_unsigned   <= w.is_unsigned;
		req_ch.apply_mask    <= w.apply_mask;
		req_ch.cycle_row     <= w.cycle_row;
		req_ch.mask_address  <= w.mask_address;
		req_ch.mask_word     <= w.mask_word;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		// word accepted at this edge
		if (w.command == CMD_LOAD) begin
			n_loads++;
			if (w.mask_address < MASK_DEPTH)
				mask_copy[w.mask_address] = w.mask_word;
		end else begin
			n_unpacks++;
			if (w.apply_mask)
				n_masked++;
			if (typed)
				pending_results.push_back(typed_result);
			else
				pending_results.push_back(unpack_lanes(w));
		end
		@(negedge clk);
	endtask

	// response checker
	always @(posedge clk) begin : check_results
		unpack_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result, expected none, got %h %h %b", $time,
					rsp_ch.dest_high, rsp_ch.dest_low, rsp_ch.bad_format);
			end else begin
				want = pending_results.pop_front();
				if (want.bad_format)
					n_bad++;
				if (rsp_ch.dest_low !== want.dest_low) begin
					n_errors++;
					$display("%0t: dest_low mismatch, expected %h, got %h", $time,
						want.dest_low, rsp_ch.dest_low);
				end
				if (rsp_ch.dest_high !== want.dest_high) begin
					n_errors++;
					$display("%0t: dest_high mismatch, expected %h, got %h", $time,
						want.dest_high, rsp_ch.dest_high);
				end
				if (rsp_ch.bad_format !== want.bad_format) begin
					n_errors++;
					$display("%0t: bad_format mismatch, expected %b, got %b", $time,
						want.bad_format, rsp_ch.bad_format);
				end
			end
		end
	end

	// stimulus
	initial begin
		req_ch.valid         = 1'b0;
		req_ch.command       = CMD_UNPACK;
		req_ch.source_low    = '0;
		req_ch.source_high   = '0;
		req_ch.old_dest_low  = '0;
		req_ch.old_dest_high = '0;
		req_ch.format        = '0;
		req_ch.is_unsigned   = 1'b0;
		req_ch.apply_mask    = 1'b0;
		req_ch.cycle_row     = '0;
		req_ch.mask_address  = '0;
		req_ch.mask_word     = '0;
		rsp_ch.ready         = 1'b0;
		no_result            = '{dest_low: '0, dest_high: '0, bad_format: 1'b0};
		foreach (mask_copy[i])
			mask_copy[i] = '0;

		// table clear after reset: masked merge gives zero
		add_typed(unpack_word({COUNT_V4, SIZE_32}, 1'b0, 1'b1, 2'd2, '1, '1, '1, '1),
			64'h0, 64'h0, 1'b0);
		// full-width extremes with no mask
		add_typed(unpack_word({COUNT_V4, SIZE_32}, 1'b0, 1'b0, 2'd0, '1, '1, '0, '0),
			'1, '1, 1'b0);
		add_typed(unpack_word({COUNT_V4, SIZE_32}, 1'b1, 1'b0, 2'd3, '0, '0, '1, '1),
			64'h0, 64'h0, 1'b0);
		// bad formats pass the old lanes, masked or not
		add_typed(unpack_word({COUNT_S, SIZE_BAD}, 1'b0, 1'b1, 2'd0, '1, '1,
			64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210),
			64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);
		add_typed(unpack_word({COUNT_V2, SIZE_BAD}, 1'b1, 1'b0, 2'd1, '0, '0, '1, '1),
			'1, '1, 1'b1);
		add_typed(unpack_word({COUNT_V3, SIZE_BAD}, 1'b0, 1'b1, 2'd3, '1, '1, '0, '0),
			64'h0, 64'h0, 1'b1);
		// sign and zero extension extremes
		add_typed(unpack_word({COUNT_S, SIZE_16}, 1'b0, 1'b0, 2'd0, 64'h8000, '0, '0, '0),
			64'hffff_8000_ffff_8000, 64'hffff_8000_ffff_8000, 1'b0);
		add_typed(unpack_word({COUNT_S, SIZE_16}, 1'b1, 1'b0, 2'd0, 64'h8000, '0, '0, '0),
			64'h0000_8000_0000_8000, 64'h0000_8000_0000_8000, 1'b0);
		add_typed(unpack_word({COUNT_S, SIZE_8}, 1'b0, 1'b0, 2'd0, 64'h80, '0, '0, '0),
			64'hffff_ff80_ffff_ff80, 64'hffff_ff80_ffff_ff80, 1'b0);
		// colour format, all bits set and only unused bytes set
		add_typed(unpack_word(FMT_V4_5, 1'b0, 1'b0, 2'd0, 64'hffff, '0, '0, '0),
			64'h0000_00f8_0000_00f8, 64'h0000_0080_0000_00f8, 1'b0);
		add_typed(unpack_word(FMT_V4_5, 1'b1, 1'b0, 2'd0, 64'hffff_ffff_ffff_0000, '1, '0, '0),
			64'h0, 64'h0, 1'b0);
		// every other vector shape
		add_checked(unpack_word({COUNT_S, SIZE_32}, 1'b0, 1'b0, 2'd0, rand64(), rand64(), '0, '0));
		add_checked(unpack_word({COUNT_V2, SIZE_32}, 1'b0, 1'b0, 2'd0, rand64(), rand64(), '0, '0));
		add_checked(unpack_word({COUNT_V2, SIZE_16}, 1'b0, 1'b0, 2'd0, rand64(), rand64(), '0, '0));
		add_checked(unpack_word({COUNT_V2, SIZE_8}, 1'b1, 1'b0, 2'd0, rand64(), rand64(), '0, '0));
		add_checked(unpack_word({COUNT_V3, SIZE_32}, 1'b0, 1'b0, 2'd0, rand64(), rand64(), '0, '0));
		add_checked(unpack_word({COUNT_V3, SIZE_16}, 1'b1, 1'b0, 2'd0, rand64(), rand64(), '0, '0));
		add_checked(unpack_word({COUNT_V3, SIZE_8}, 1'b0, 1'b0, 2'd0, rand64(), rand64(), '0, '0));
		add_checked(unpack_word({COUNT_V4, SIZE_16}, 1'b0, 1'b0, 2'd0, rand64(), rand64(), '0, '0));
		add_checked(unpack_word({COUNT_V4, SIZE_8}, 1'b1, 1'b0, 2'd0, rand64(), rand64(), '0, '0));
		// table loads, including addresses past the end of the table
		add_checked(load_word({KIND_KEEP, 2'd1, 2'd0}, 32'hffff_0000));
		add_checked(load_word({KIND_OLD_KEEP, 2'd1, 2'd0}, 32'h0000_ffff));
		add_checked(load_word({KIND_FILL, 2'd1, 2'd1}, 32'h8000_0001));
		add_checked(load_word({KIND_KEEP, ROW_LAST, 2'd3}, '1));
		add_checked(load_word(6'(MASK_DEPTH), '1));
		add_checked(load_word(6'h3f, '1));
		// masked merges on the loaded rows and the untouched first row
		add_checked(unpack_word({COUNT_V4, SIZE_32}, 1'b0, 1'b1, 2'd1, rand64(), rand64(),
			rand64(), rand64()));
		add_checked(unpack_word({COUNT_V4, SIZE_32}, 1'b0, 1'b1, ROW_LAST, rand64(), rand64(),
			rand64(), rand64()));
		add_checked(unpack_word({COUNT_V4, SIZE_32}, 1'b0, 1'b1, 2'd0, '1, '1, '1, '1));

		// reset
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (directed_rows[i])
			send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].result);

		// random words under three pacing phases
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct  = (phase == 0) ? 15 : (phase == 1) ? 78 : 0;
			rx_stall_pct = (phase == 0) ? 78 : (phase == 1) ? 15 : 0;
			repeat (RANDOM_PER_PHASE)
				send_word(random_word(), 1'b0, no_result);
		end
		req_ch.valid <= 1'b0;

		// drain, then allow for the pipeline depth
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("run covered %0d unpack words (%0d masked, %0d bad format) and %0d table loads",
			n_unpacks, n_masked, n_bad, n_loads);
		$display("%0d results checked over three pacing phases, %0d mismatches", n_results,
			n_errors);
		if (n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/vumask_pkg.sv
rtl/vumask_ifs.sv
rtl/vumask_ram.sv
rtl/vumask_table.sv
rtl/vumask_unpack.sv
rtl/vector_unpack_mask_engine_unit.sv
rtl/vumask_checker.sv
tb/testbench.sv
